// ===== rtl/core/fhd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fhd_pkg
// shared types and constants of the frame header deframer
// ---------------------------------------------------------------------------
package fhd_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_END    = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_VERSION  = 3'd1;
	localparam logic [2:0] ERR_SIZE     = 3'd2;
	localparam logic [2:0] ERR_RESERVED = 3'd3;
	localparam logic [2:0] ERR_END_MARK = 3'd4;

	localparam logic [7:0]  END_MARK = 8'hCE;
	localparam logic [15:0] HDR_LEN  = 16'd12;

	typedef struct packed {
		logic [3:0]  flags;
		logic [7:0]  seg_type;
		logic [15:0] channel;
		logic [3:0]  subchannel;
		logic [15:0] body_length;
	} hdr_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  error_code;
		hdr_t        hdr;
		logic [7:0]  data;
		logic        last;
	} entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/fhd_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fhd_front
// byte parser: walks the header, counts the body and checks the end marker,
// classifying each byte into at most one queue entry
// ---------------------------------------------------------------------------
module fhd_front import fhd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	output logic            res_valid,
	output entry_t          res
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_END    = 2'd2
	} phase_t;

	localparam logic [3:0] IDX_LAST = 4'd11;

	phase_t      phase_q, phase_n;
	logic [3:0]  idx_q, idx_n, idx_e;
	logic [3:0]  flags_q, flags_n;
	logic [7:0]  type_q, type_n;
	logic [15:0] size_q, size_n;
	logic [15:0] chan_q, chan_n;
	logic [3:0]  sub_q, sub_n;
	logic        rsv_q, rsv_n;
	logic [15:0] rem_q, rem_n;
	logic        err;
	logic [2:0]  err_code;

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		flags_n   = flags_q;
		type_n    = type_q;
		size_n    = size_q;
		chan_n    = chan_q;
		sub_n     = sub_q;
		rsv_n     = rsv_q;
		rem_n     = rem_q;
		err       = 1'b0;
		err_code  = ERR_NONE;
		res_valid = 1'b0;
		res       = '0;
		idx_e     = 4'd0;
		case (phase_q)
			PH_BODY: begin
				rem_n     = rem_q - 16'd1;
				res_valid = 1'b1;
				res.kind  = KIND_BODY;
				res.data  = in_byte;
				res.last  = (rem_n == 16'd0);
				if (rem_n == 16'd0) begin
					phase_n = PH_END;
				end
			end
			PH_END: begin
				res_valid = 1'b1;
				phase_n   = PH_HEADER;
				idx_n     = 4'd0;
				rsv_n     = 1'b0;
				if (in_byte != END_MARK) begin
					res.kind       = KIND_ERROR;
					res.error_code = ERR_END_MARK;
				end else begin
					res.kind = KIND_END;
				end
			end
			default: begin
				if (phase_q == PH_HEADER && idx_q <= IDX_LAST) begin
					idx_e = idx_q;
				end else begin
					idx_e = 4'd0;
					rsv_n = 1'b0;
				end
				case (idx_e)
					4'd0: begin
						if (in_byte[7:6] != 2'b00) begin
							err      = 1'b1;
							err_code = ERR_VERSION;
						end else begin
							flags_n = in_byte[3:0];
							if (in_byte[5:4] != 2'b00) begin
								rsv_n = 1'b1;
							end
						end
					end
					4'd1: begin
						type_n = in_byte;
					end
					4'd2: begin
						size_n = {in_byte, 8'h00};
					end
					4'd3: begin
						size_n = {size_q[15:8], in_byte};
						if (size_n < HDR_LEN) begin
							err      = 1'b1;
							err_code = ERR_SIZE;
						end
					end
					4'd4: begin
						if (in_byte != 8'h00) begin
							rsv_n = 1'b1;
						end
					end
					4'd5: begin
						sub_n = in_byte[3:0];
						if (in_byte[7:4] != 4'h0) begin
							rsv_n = 1'b1;
						end
					end
					4'd6: begin
						chan_n = {in_byte, 8'h00};
					end
					4'd7: begin
						chan_n = {chan_q[15:8], in_byte};
					end
					default: begin
					end
				endcase
				if (!err && idx_e == IDX_LAST && rsv_n) begin
					err      = 1'b1;
					err_code = ERR_RESERVED;
				end
				if (err) begin
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = err_code;
					phase_n        = PH_HEADER;
					idx_n          = 4'd0;
					rsv_n          = 1'b0;
				end else if (idx_e == IDX_LAST) begin
					res_valid              = 1'b1;
					res.kind               = KIND_HEADER;
					res.hdr.flags          = flags_n;
					res.hdr.seg_type       = type_n;
					res.hdr.channel        = chan_n;
					res.hdr.subchannel     = sub_n;
					res.hdr.body_length    = size_n - HDR_LEN;
					rem_n                  = size_n - HDR_LEN;
					idx_n                  = 4'd0;
					phase_n                = (rem_n == 16'd0) ? PH_END : PH_BODY;
				end else begin
					phase_n = PH_HEADER;
					idx_n   = idx_e + 4'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= 4'd0;
			flags_q <= 4'd0;
			type_q  <= 8'd0;
			size_q  <= 16'd0;
			chan_q  <= 16'd0;
			sub_q   <= 4'd0;
			rsv_q   <= 1'b0;
			rem_q   <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			flags_q <= flags_n;
			type_q  <= type_n;
			size_q  <= size_n;
			chan_q  <= chan_n;
			sub_q   <= sub_n;
			rsv_q   <= rsv_n;
			rem_q   <= rem_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fhd_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fhd_queue
// short first-in first-out queue between parser and output stage
// ---------------------------------------------------------------------------
module fhd_queue import fhd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  entry_t      wr_data,
	output logic        q_full,
	output logic        q_valid,
	input  wire logic   rd_en,
	output entry_t      rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr, do_rd;

	assign q_full  = (cnt_q == CNT_FULL);
	assign q_valid = (cnt_q != '0);
	assign rd_data = mem_q[rptr_q];
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fhd_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fhd_back
// output stage: holds the current frame header and builds each result
// into the output register
// ---------------------------------------------------------------------------
module fhd_back import fhd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  entry_t      q_data,
	output logic        q_take,
	output logic        out_valid,
	input  wire logic   out_pop,
	output logic [1:0]  out_kind,
	output logic [2:0]  out_error_code,
	output hdr_t        out_hdr,
	output logic [7:0]  out_data,
	output logic        out_last
);

	logic        valid_q;
	hdr_t        hdr_q;
	logic [1:0]  kind_q;
	logic [2:0]  code_q;
	hdr_t        ohdr_q;
	logic [7:0]  data_q;
	logic        last_q;

	assign q_take         = q_valid && (!valid_q || out_pop);
	assign out_valid      = valid_q;
	assign out_kind       = kind_q;
	assign out_error_code = code_q;
	assign out_hdr        = ohdr_q;
	assign out_data       = data_q;
	assign out_last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_take) begin
			valid_q <= 1'b1;
		end else if (out_pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			kind_q <= q_data.kind;
			code_q <= ERR_NONE;
			data_q <= 8'd0;
			last_q <= 1'b0;
			case (q_data.kind)
				KIND_HEADER: begin
					hdr_q  <= q_data.hdr;
					ohdr_q <= q_data.hdr;
				end
				KIND_BODY: begin
					ohdr_q <= hdr_q;
					data_q <= q_data.data;
					last_q <= q_data.last;
				end
				KIND_END: begin
					ohdr_q <= hdr_q;
				end
				default: begin
					ohdr_q <= '0;
					code_q <= q_data.error_code;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/frame_header_deframer_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frame_header_deframer_unit
// path: each result goes from the parser through the queue into the output register
// throughput: one byte per cycle while full is low; the parser handles each accepted byte
// reset: arst_n clears the parser to header byte 0 and empties queue and output
// ---------------------------------------------------------------------------
module frame_header_deframer_unit import fhd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [2:0]       error_code,
	output logic [3:0]       frame_flags,
	output logic [7:0]       segment_type,
	output logic [15:0]      channel_number,
	output logic [3:0]       subchannel_number,
	output logic [15:0]      body_length,
	output logic [7:0]       body_byte,
	output logic             last_body_byte
);

	logic    accept;
	logic    res_valid;
	entry_t  res;
	logic    q_full, q_valid, q_take;
	entry_t  q_data;
	logic    out_valid;
	hdr_t    out_hdr;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign empty  = !out_valid;

	fhd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	fhd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && res_valid),
		.wr_data (res),
		.q_full  (q_full),
		.q_valid (q_valid),
		.rd_en   (q_take),
		.rd_data (q_data)
	);

	fhd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_data         (q_data),
		.q_take         (q_take),
		.out_valid      (out_valid),
		.out_pop        (pop),
		.out_kind       (kind),
		.out_error_code (error_code),
		.out_hdr        (out_hdr),
		.out_data       (body_byte),
		.out_last       (last_body_byte)
	);

	assign frame_flags       = out_hdr.flags;
	assign segment_type      = out_hdr.seg_type;
	assign channel_number    = out_hdr.channel;
	assign subchannel_number = out_hdr.subchannel;
	assign body_length       = out_hdr.body_length;

endmodule
`default_nettype wire
